// File: src/wjsm_pkg.sv
// Shared constants and codes for the weighted Jaccard sorted-merge unit.
`default_nettype none
package wjsm_pkg;
    localparam int ID_BITS     = 31;
    localparam int WIN_BITS    = 20;
    localparam int SUM_BITS    = 31;
    localparam int RATIO_BITS  = 17;
    localparam int CMD_BITS    = 2;

    localparam logic [CMD_BITS-1:0] CMD_LOAD_A  = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_LOAD_B  = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_COMPUTE = 2'd2;
endpackage
`default_nettype wire

// File: src/wjsm_div.sv
// Restoring divider, one quotient bit per cycle, for the fixed-point ratio.
`default_nettype none
module wjsm_div #(
    parameter int FRAC_BITS = 16
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_start,
    input  wire  [wjsm_pkg::SUM_BITS-1:0]        i_dividend,
    input  wire  [wjsm_pkg::SUM_BITS-1:0]        i_divisor,
    output logic                                 o_done,
    output logic [wjsm_pkg::RATIO_BITS-1:0]      o_quot
);
    localparam int SB = wjsm_pkg::SUM_BITS;
    localparam int QW = FRAC_BITS + 1;
    localparam int KW = $clog2(QW + 1);
    localparam int RW = (QW > wjsm_pkg::RATIO_BITS) ? QW : wjsm_pkg::RATIO_BITS;

    logic          r_run;
    logic          r_done;
    logic [KW-1:0] r_cnt;
    logic [SB-1:0] r_rem;
    logic [SB-1:0] r_div;
    logic [QW-1:0] r_quot;

    logic [SB:0]   t_val;
    logic [SB:0]   diff;
    logic          ge;
    logic [RW-1:0] quot_ext;

    // First step compares the dividend as is; later steps shift in a zero bit.
    always_comb begin
        t_val = (r_cnt == '0) ? {1'b0, r_rem} : {r_rem, 1'b0};
        ge    = t_val >= {1'b0, r_div};
        diff  = t_val - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (r_run) begin
                r_rem  <= ge ? diff[SB-1:0] : t_val[SB-1:0];
                r_quot <= {r_quot[QW-2:0], ge};
                if (r_cnt == KW'(QW - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + KW'(1);
            end else if (i_start) begin
                r_rem  <= i_dividend;
                r_div  <= i_divisor;
                r_quot <= '0;
                r_cnt  <= '0;
                // empty union: report zero at once
                if (i_divisor == '0) begin
                    r_done <= 1'b1;
                end else begin
                    r_run <= 1'b1;
                end
            end
        end
    end

    assign quot_ext = RW'(r_quot);
    assign o_quot   = quot_ext[wjsm_pkg::RATIO_BITS-1:0];
    assign o_done   = r_done;
endmodule
`default_nettype wire

// File: src/weighted_jaccard_sorted_merge_unit.sv
// Loads run at one transfer per cycle while the unit is idle. A compute first merges
// the two lists, each merge step taking the entry with the smaller ID, or one entry from
// each list when the IDs match, then runs the divider, then raises the result strobe.
// busy is high in the merge and divide states and drops as o_valid rises; results
// cannot be stalled. Reset clears list counts, indices, the drop flag, o_valid and the
// sequencer; list memories are not cleared, as only entries below the counts are used.
`default_nettype none
module weighted_jaccard_sorted_merge_unit #(
    parameter int LIST_DEPTH  = 1024,
    parameter int WEIGHT_BITS = 20,
    parameter int FRAC_BITS   = 16
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   start,
    output logic                                  busy,
    input  wire  [wjsm_pkg::CMD_BITS-1:0]         i_cmd,
    input  wire  [wjsm_pkg::ID_BITS-1:0]          i_node_id,
    input  wire  [wjsm_pkg::WIN_BITS-1:0]         i_weight,
    output logic                                  o_valid,
    output logic [wjsm_pkg::RATIO_BITS-1:0]       o_ratio_q16,
    output logic [wjsm_pkg::SUM_BITS-1:0]         o_inter_sum,
    output logic [wjsm_pkg::SUM_BITS-1:0]         o_union_sum,
    output logic                                  o_truncated
);
    localparam int WB = (WEIGHT_BITS < wjsm_pkg::WIN_BITS) ? WEIGHT_BITS
                                                            : wjsm_pkg::WIN_BITS;
    localparam int IB = wjsm_pkg::ID_BITS;
    localparam int SB = wjsm_pkg::SUM_BITS;
    localparam int DW = IB + WB;
    localparam int IW = $clog2(LIST_DEPTH);
    localparam int CW = $clog2(LIST_DEPTH + 1);

    typedef enum logic [1:0] {S_IDLE, S_MERGE, S_DIV} t_state;

    logic [DW-1:0] mem_a [LIST_DEPTH];
    logic [DW-1:0] mem_b [LIST_DEPTH];
    logic [DW-1:0] rd_a;
    logic [DW-1:0] rd_b;

    t_state  r_state, n_state;
    logic [CW-1:0] r_cnt_a, n_cnt_a;
    logic [CW-1:0] r_cnt_b, n_cnt_b;
    logic [CW-1:0] r_ia, n_ia;
    logic [CW-1:0] r_ib, n_ib;
    logic          r_drop, n_drop;
    logic [SB-1:0] r_inter, n_inter;
    logic [SB-1:0] r_union, n_union;
    logic          r_valid, n_valid;
    logic          r_trunc, n_trunc;
    logic [wjsm_pkg::RATIO_BITS-1:0] r_ratio, n_ratio;

    logic          wr_a, wr_b;
    logic          div_start, div_done;
    logic [wjsm_pkg::RATIO_BITS-1:0] div_quot;
    logic          a_has, b_has;
    logic [IB-1:0] id_a, id_b;
    logic [WB-1:0] w_a, w_b, w_sel;
    logic          add_u, add_i;
    logic [SB:0]   u_sum, i_sum;

    assign id_a = rd_a[DW-1:WB];
    assign id_b = rd_b[DW-1:WB];
    assign w_a  = rd_a[WB-1:0];
    assign w_b  = rd_b[WB-1:0];
    assign a_has = r_ia < r_cnt_a;
    assign b_has = r_ib < r_cnt_b;

    // Saturating accumulators shared by every merge step.
    assign u_sum = {1'b0, r_union} + (SB+1)'(w_sel);
    assign i_sum = {1'b0, r_inter} + (SB+1)'(w_sel);

    always_comb begin
        n_state   = r_state;
        n_cnt_a   = r_cnt_a;
        n_cnt_b   = r_cnt_b;
        n_ia      = r_ia;
        n_ib      = r_ib;
        n_drop    = r_drop;
        n_inter   = r_inter;
        n_union   = r_union;
        n_valid   = 1'b0;
        n_trunc   = r_trunc;
        n_ratio   = r_ratio;
        wr_a      = 1'b0;
        wr_b      = 1'b0;
        div_start = 1'b0;
        w_sel     = w_a;
        add_u     = 1'b0;
        add_i     = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (i_cmd)
                        wjsm_pkg::CMD_LOAD_A: begin
                            if (r_cnt_a == CW'(LIST_DEPTH)) begin
                                n_drop = 1'b1;
                            end else begin
                                wr_a    = 1'b1;
                                n_cnt_a = r_cnt_a + CW'(1);
                            end
                        end
                        wjsm_pkg::CMD_LOAD_B: begin
                            if (r_cnt_b == CW'(LIST_DEPTH)) begin
                                n_drop = 1'b1;
                            end else begin
                                wr_b    = 1'b1;
                                n_cnt_b = r_cnt_b + CW'(1);
                            end
                        end
                        wjsm_pkg::CMD_COMPUTE: begin
                            n_inter = '0;
                            n_union = '0;
                            n_state = S_MERGE;
                        end
                        default: ;
                    endcase
                end
            end
            S_MERGE: begin
                if (a_has && b_has) begin
                    add_u = 1'b1;
                    if (id_a == id_b) begin
                        add_i = 1'b1;
                        n_ia  = r_ia + CW'(1);
                        n_ib  = r_ib + CW'(1);
                    end else if (id_a < id_b) begin
                        n_ia  = r_ia + CW'(1);
                    end else begin
                        w_sel = w_b;
                        n_ib  = r_ib + CW'(1);
                    end
                end else if (a_has) begin
                    add_u = 1'b1;
                    n_ia  = r_ia + CW'(1);
                end else if (b_has) begin
                    add_u = 1'b1;
                    w_sel = w_b;
                    n_ib  = r_ib + CW'(1);
                end else begin
                    div_start = 1'b1;
                    n_state   = S_DIV;
                end
                if (add_u) begin
                    n_union = u_sum[SB] ? '1 : u_sum[SB-1:0];
                end
                if (add_i) begin
                    n_inter = i_sum[SB] ? '1 : i_sum[SB-1:0];
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_valid = 1'b1;
                    n_ratio = div_quot;
                    n_trunc = r_drop;
                    n_drop  = 1'b0;
                    n_cnt_a = '0;
                    n_cnt_b = '0;
                    n_ia    = '0;
                    n_ib    = '0;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt_a <= '0;
            r_cnt_b <= '0;
            r_ia    <= '0;
            r_ib    <= '0;
            r_drop  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt_a <= n_cnt_a;
            r_cnt_b <= n_cnt_b;
            r_ia    <= n_ia;
            r_ib    <= n_ib;
            r_drop  <= n_drop;
            r_valid <= n_valid;
        end
        r_inter <= n_inter;
        r_union <= n_union;
        r_trunc <= n_trunc;
        r_ratio <= n_ratio;
    end

    // Read at the next index so the entry is ready when the step uses it.
    always_ff @(posedge i_clk) begin
        if (wr_a) begin
            mem_a[r_cnt_a[IW-1:0]] <= {i_node_id, i_weight[WB-1:0]};
        end
        rd_a <= mem_a[n_ia[IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (wr_b) begin
            mem_b[r_cnt_b[IW-1:0]] <= {i_node_id, i_weight[WB-1:0]};
        end
        rd_b <= mem_b[n_ib[IW-1:0]];
    end

    wjsm_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_inter),
        .i_divisor  (r_union),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    assign busy        = (r_state != S_IDLE);
    assign o_valid     = r_valid;
    assign o_ratio_q16 = r_ratio;
    assign o_inter_sum = r_inter;
    assign o_union_sum = r_union;
    assign o_truncated = r_trunc;
endmodule
`default_nettype wire
